// ===== rtl/rscbw_pkg.sv =====
package rscbw_pkg;

  // block limits
  localparam int MAX_TRACKED = 3;
  localparam int MAX_BIN     = 2047;

  // field widths
  localparam int AZ_W    = 13;
  localparam int RANGE_W = 15;
  localparam int RAD_W   = 12;
  localparam int BIN_W   = 12;
  localparam int CFG_W   = 15;
  localparam int MINB_W  = 13;

  // shared unit widths
  localparam int MUL_AW  = 34;
  localparam int MUL_BW  = 32;
  localparam int MUL_PW  = MUL_AW + MUL_BW;
  localparam int DIV_W   = 32;
  localparam int DVS_W   = 12;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int RECIP_W = 32;
  localparam int RSH_W   = 6;

  // fixed-point constants
  localparam logic [AZ_W-1:0]   AZ_FULL  = 13'd5760;
  localparam logic [AZ_W-1:0]   AZ_HALF  = 13'd2880;
  localparam logic [AZ_W-1:0]   AZ_QUAD  = 13'd1440;
  localparam logic [AZ_W-1:0]   AZ_OCT   = 13'd720;
  localparam logic [20:0]       RAD_K    = 21'd1171271;
  localparam logic [30:0]       ONE_Q30  = 31'h4000_0000;
  localparam logic [9:0]        M_PER_KM = 10'd1000;
  localparam logic [RAD_W-1:0]  RAD_RST  = 12'd1280;
  localparam logic [BIN_W-1:0]  NONE_FIRST = BIN_W'(MAX_BIN + 1);

  // register indexes
  localparam logic [2:0] CFG_STORM_COUNT = 3'd0;
  localparam logic [2:0] CFG_S0_RANGE    = 3'd1;
  localparam logic [2:0] CFG_S0_AZ       = 3'd2;
  localparam logic [2:0] CFG_S1_RANGE    = 3'd3;
  localparam logic [2:0] CFG_S1_AZ       = 3'd4;
  localparam logic [2:0] CFG_S2_RANGE    = 3'd5;
  localparam logic [2:0] CFG_S2_AZ       = 3'd6;
  localparam logic [2:0] CFG_RADIUS      = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ANG0, ST_ANG1, ST_X, ST_X2, ST_X2S, ST_DIV, ST_HMUL, ST_HDIV,
    ST_SINM, ST_SINR, ST_B, ST_BR, ST_BB, ST_R0, ST_RR, ST_CMP, ST_SQS, ST_SQ,
    ST_FAR, ST_FM, ST_FD, ST_FDW, ST_NM, ST_ND, ST_NDW, ST_NEXT, ST_DONE
  } state_t;

  // horner divisions as (n * m) >> s, exact for n below 2^30
  // cosine divisors 56, 30, 12, 2; sine divisors 72, 42, 20, 6
  function automatic logic [RECIP_W-1:0] horner_recip(input logic use_sin,
                                                      input logic [1:0] step);
    logic [RECIP_W-1:0] r;
    case (step)
      2'd0:    r = use_sin ? 32'd1908874354 : 32'd1227133514;
      2'd1:    r = use_sin ? 32'd1636178018 : 32'd1145324613;
      2'd2:    r = use_sin ? 32'd1717986919 : 32'd1431655766;
      default: r = use_sin ? 32'd1431655766 : 32'd1073741824;
    endcase
    return r;
  endfunction

  function automatic logic [RSH_W-1:0] horner_shift(input logic use_sin,
                                                    input logic [1:0] step);
    logic [RSH_W-1:0] r;
    case (step)
      2'd0:    r = use_sin ? 6'd37 : 6'd36;
      2'd1:    r = use_sin ? 6'd36 : 6'd35;
      2'd2:    r = use_sin ? 6'd35 : 6'd34;
      default: r = use_sin ? 6'd33 : 6'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rscbw_div.sv =====
module rscbw_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rscbw_pkg::DIV_W-1:0] dividend,
  input  logic [rscbw_pkg::DVS_W-1:0] divisor,
  output logic                        done,
  output logic [rscbw_pkg::DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(rscbw_pkg::DIV_W);

  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [rscbw_pkg::DIV_W-1:0] dvd_r, dvd_nxt;
  logic [rscbw_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [rscbw_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [rscbw_pkg::DVS_W:0]   sh;
  logic                        ge;

  // one quotient bit per cycle, restoring
  assign sh = {rem_r, dvd_r[rscbw_pkg::DIV_W-1]};
  assign ge = sh >= {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      rem_nxt = ge ? rscbw_pkg::DVS_W'(sh - {1'b0, dvs_r})
                   : sh[rscbw_pkg::DVS_W-1:0];
      dvd_nxt = {dvd_r[rscbw_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(rscbw_pkg::DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ===== rtl/rscbw_sqrt.sv =====
module rscbw_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rscbw_pkg::SQ_W-1:0]   radicand,
  output logic                         done,
  output logic [rscbw_pkg::ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(rscbw_pkg::ROOT_W);

  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [rscbw_pkg::SQ_W-1:0] v_r, v_nxt;
  logic [rscbw_pkg::SQ_W-1:0] res_r, res_nxt;
  logic [rscbw_pkg::SQ_W-1:0] bit_r, bit_nxt;
  logic [rscbw_pkg::SQ_W-1:0] trial;
  logic [rscbw_pkg::SQ_W:0]   diff;

  // res never overlaps the current bit, so the trial sum is an or
  assign trial = res_r | bit_r;
  assign diff  = {1'b0, v_r} - {1'b0, trial};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      v_nxt   = radicand;
      res_nxt = '0;
      bit_nxt = {2'b01, {(rscbw_pkg::SQ_W-2){1'b0}}};
    end else if (run_r) begin
      if (!diff[rscbw_pkg::SQ_W]) begin
        v_nxt   = diff[rscbw_pkg::SQ_W-1:0];
        res_nxt = (res_r >> 1) | bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(rscbw_pkg::ROOT_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[rscbw_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/radial_storm_circle_bin_window.sv =====
// Radial / storm-circle bin window.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 storm count, 1..6 range/azimuth of storms 0..2, 7 circle radius).
// Write only while busy is low.
// Input: a radial word is taken at an edge with start high and busy low.
// busy then stays high until the window is ready.
// Output: out_valid is high for one cycle with the window word on
// out_window_first / out_window_last / out_no_storm_hit; the receiver must
// take it in that cycle.
// With no storms the sequencer goes straight from accept to the result. The work
// per valid storm depends on whether the circle misses the radial line, lies
// behind the radar, holds the radar inside it or is crossed in full, and grows
// on the sine side of the fold. The series divisions are reciprocal multiplies
// on one shared multiplier; the 64-bit square root and the one or two bin
// divisions are bit-serial.
// The next radial can start in the cycle out_valid is shown.
// Reset: clears the sequencer and the configuration (radius 1280, all
// else 0); no clearing pass is needed.
module radial_storm_circle_bin_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rscbw_pkg::AZ_W-1:0]      in_radial_azimuth,
  input  logic [rscbw_pkg::BIN_W-1:0]     in_bin_size_m,
  input  logic [rscbw_pkg::BIN_W-1:0]     in_radial_first_bin,
  input  logic [rscbw_pkg::BIN_W-1:0]     in_radial_last_bin,
  output logic                            out_valid,
  output logic [rscbw_pkg::BIN_W-1:0]     out_window_first,
  output logic [rscbw_pkg::BIN_W-1:0]     out_window_last,
  output logic                            out_no_storm_hit,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [rscbw_pkg::CFG_W-1:0]     cfg_data
);

  // configuration
  logic [1:0]                       storm_count_r;
  logic [rscbw_pkg::RANGE_W-1:0]    storm_range_r [rscbw_pkg::MAX_TRACKED];
  logic [rscbw_pkg::AZ_W-1:0]       storm_az_r    [rscbw_pkg::MAX_TRACKED];
  logic [rscbw_pkg::RAD_W-1:0]      radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      storm_count_r <= '0;
      radius_r      <= rscbw_pkg::RAD_RST;
      for (int k = 0; k < rscbw_pkg::MAX_TRACKED; k++) begin
        storm_range_r[k] <= '0;
        storm_az_r[k]    <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        rscbw_pkg::CFG_STORM_COUNT: storm_count_r    <= cfg_data[1:0];
        rscbw_pkg::CFG_S0_RANGE:    storm_range_r[0] <= cfg_data;
        rscbw_pkg::CFG_S0_AZ:       storm_az_r[0]    <= cfg_data[12:0];
        rscbw_pkg::CFG_S1_RANGE:    storm_range_r[1] <= cfg_data;
        rscbw_pkg::CFG_S1_AZ:       storm_az_r[1]    <= cfg_data[12:0];
        rscbw_pkg::CFG_S2_RANGE:    storm_range_r[2] <= cfg_data;
        rscbw_pkg::CFG_S2_AZ:       storm_az_r[2]    <= cfg_data[12:0];
        rscbw_pkg::CFG_RADIUS:      radius_r         <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  rscbw_pkg::state_t state_r, state_nxt;
  logic [rscbw_pkg::AZ_W-1:0]   az1_r, az1_nxt;
  logic [rscbw_pkg::BIN_W-1:0]  bsz_r, bsz_nxt;
  logic [rscbw_pkg::BIN_W-1:0]  fg_r, fg_nxt;
  logic [rscbw_pkg::BIN_W-1:0]  lg_r, lg_nxt;
  logic [1:0]                   idx_r, idx_nxt;
  logic [rscbw_pkg::AZ_W-1:0]   d_r, d_nxt;
  logic [10:0]                  t_r, t_nxt;
  logic                         neg_r, neg_nxt;
  logic                         sin_r, sin_nxt;
  logic [29:0]                  x_r, x_nxt;
  logic [29:0]                  x2_r, x2_nxt;
  logic [30:0]                  p_r, p_nxt;
  logic [1:0]                   step_r, step_nxt;
  logic [31:0]                  b_r, b_nxt;
  logic [29:0]                  r02_r, r02_nxt;
  logic [63:0]                  q_r, q_nxt;
  logic [31:0]                  s_r, s_nxt;
  logic [32:0]                  far_r, far_nxt;
  logic signed [34:0]           near_r, near_nxt;
  logic                         hit_r, hit_nxt;
  logic [rscbw_pkg::MINB_W-1:0] minb_r, minb_nxt;
  logic [rscbw_pkg::BIN_W-1:0]  maxb_r, maxb_nxt;
  logic                         ov_r, ov_nxt;
  logic [rscbw_pkg::BIN_W-1:0]  of_r, of_nxt;
  logic [rscbw_pkg::BIN_W-1:0]  ol_r, ol_nxt;
  logic                         on_r, on_nxt;

  // shared multiplier, product registered
  logic [rscbw_pkg::MUL_AW-1:0] mul_a;
  logic [rscbw_pkg::MUL_BW-1:0] mul_b;
  logic [rscbw_pkg::MUL_PW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // series quotient from the reciprocal product
  logic [rscbw_pkg::MUL_PW-1:0] rec_q;
  assign rec_q = prod_r >> rscbw_pkg::horner_shift(sin_r, step_r);

  // shared divider and root unit
  logic                          div_start, div_done;
  logic [rscbw_pkg::DIV_W-1:0]   div_dvd, div_quot;
  logic [rscbw_pkg::DVS_W-1:0]   div_dvs;
  logic                          sq_start, sq_done;
  logic [rscbw_pkg::ROOT_W-1:0]  sq_root;

  rscbw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quot)
  );

  rscbw_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (q_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // azimuth difference, first stage
  logic [rscbw_pkg::AZ_W-1:0] az_in_red, az0_raw, az0_red;
  logic [rscbw_pkg::AZ_W:0]   dsum;
  assign az_in_red = (in_radial_azimuth >= rscbw_pkg::AZ_FULL) ?
                     in_radial_azimuth - rscbw_pkg::AZ_FULL : in_radial_azimuth;
  assign az0_raw   = storm_az_r[idx_r];
  assign az0_red   = (az0_raw >= rscbw_pkg::AZ_FULL) ?
                     az0_raw - rscbw_pkg::AZ_FULL : az0_raw;
  assign dsum      = {1'b0, az1_r} + {1'b0, rscbw_pkg::AZ_FULL} - {1'b0, az0_red};

  // quadrant fold, second stage
  logic [rscbw_pkg::AZ_W-1:0] e_ang, a_ang;
  logic                       neg_ang, sin_ang;
  assign e_ang   = (d_r > rscbw_pkg::AZ_HALF) ? rscbw_pkg::AZ_FULL - d_r : d_r;
  assign neg_ang = e_ang > rscbw_pkg::AZ_QUAD;
  assign a_ang   = neg_ang ? rscbw_pkg::AZ_HALF - e_ang : e_ang;
  assign sin_ang = a_ang > rscbw_pkg::AZ_OCT;

  // crossings and bins
  logic [rscbw_pkg::RANGE_W-1:0] r0;
  logic [45:0]                   b_round;
  logic [64:0]                   qdiff;
  logic signed [34:0]            sb, s_ext, far_s, near_s;
  logic [32:0]                   q1;
  logic [rscbw_pkg::BIN_W-1:0]   r2b;
  logic [32:0]                   r1b;

  assign r0      = storm_range_r[idx_r];
  assign b_round = prod_r[45:0] + 46'd8192;
  assign qdiff   = {1'b0, q_r} - {3'd0, r02_r, 32'd0};
  assign sb      = neg_r ? -$signed({3'b0, b_r}) : $signed({3'b0, b_r});
  assign s_ext   = $signed({3'b0, s_r});
  assign far_s   = sb + s_ext;
  assign near_s  = sb - s_ext;
  assign q1      = {1'b0, div_quot} + 33'd1;
  assign r2b     = (q1 > {21'd0, lg_r}) ? lg_r : q1[rscbw_pkg::BIN_W-1:0];
  assign r1b     = (q1 < {21'd0, fg_r}) ? {21'd0, fg_r} : q1;

  // next state and datapath control
  always_comb begin
    state_nxt = state_r;
    az1_nxt   = az1_r;
    bsz_nxt   = bsz_r;
    fg_nxt    = fg_r;
    lg_nxt    = lg_r;
    idx_nxt   = idx_r;
    d_nxt     = d_r;
    t_nxt     = t_r;
    neg_nxt   = neg_r;
    sin_nxt   = sin_r;
    x_nxt     = x_r;
    x2_nxt    = x2_r;
    p_nxt     = p_r;
    step_nxt  = step_r;
    b_nxt     = b_r;
    r02_nxt   = r02_r;
    q_nxt     = q_r;
    s_nxt     = s_r;
    far_nxt   = far_r;
    near_nxt  = near_r;
    hit_nxt   = hit_r;
    minb_nxt  = minb_r;
    maxb_nxt  = maxb_r;
    ov_nxt    = 1'b0;
    of_nxt    = of_r;
    ol_nxt    = ol_r;
    on_nxt    = on_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    sq_start  = 1'b0;
    case (state_r)
      rscbw_pkg::ST_IDLE: begin
        if (start) begin
          az1_nxt  = az_in_red;
          bsz_nxt  = (in_bin_size_m == '0) ? 12'd1 : in_bin_size_m;
          fg_nxt   = in_radial_first_bin;
          lg_nxt   = in_radial_last_bin;
          idx_nxt  = '0;
          hit_nxt  = 1'b0;
          minb_nxt = rscbw_pkg::MINB_W'(rscbw_pkg::MAX_BIN + 1);
          maxb_nxt = '0;
          state_nxt = (storm_count_r == '0) ? rscbw_pkg::ST_DONE : rscbw_pkg::ST_ANG0;
        end
      end
      rscbw_pkg::ST_ANG0: begin
        d_nxt = (dsum >= {1'b0, rscbw_pkg::AZ_FULL}) ?
                rscbw_pkg::AZ_W'(dsum - {1'b0, rscbw_pkg::AZ_FULL}) : dsum[12:0];
        state_nxt = rscbw_pkg::ST_ANG1;
      end
      rscbw_pkg::ST_ANG1: begin
        neg_nxt = neg_ang;
        sin_nxt = sin_ang;
        t_nxt   = sin_ang ? 11'(rscbw_pkg::AZ_QUAD - a_ang) : a_ang[10:0];
        state_nxt = rscbw_pkg::ST_X;
      end
      rscbw_pkg::ST_X: begin
        mul_a = {23'd0, t_r};
        mul_b = {11'd0, rscbw_pkg::RAD_K};
        state_nxt = rscbw_pkg::ST_X2;
      end
      rscbw_pkg::ST_X2: begin
        x_nxt = prod_r[29:0];
        mul_a = {4'd0, prod_r[29:0]};
        mul_b = {2'd0, prod_r[29:0]};
        state_nxt = rscbw_pkg::ST_X2S;
      end
      rscbw_pkg::ST_X2S: begin
        x2_nxt    = prod_r[59:30];
        mul_a     = {4'd0, prod_r[59:30]};
        mul_b     = rscbw_pkg::horner_recip(sin_r, 2'd0);
        step_nxt  = '0;
        state_nxt = rscbw_pkg::ST_DIV;
      end
      rscbw_pkg::ST_DIV: begin
        p_nxt = rscbw_pkg::ONE_Q30 - rec_q[30:0];
        if (step_r == 2'd3) begin
          state_nxt = sin_r ? rscbw_pkg::ST_SINM : rscbw_pkg::ST_B;
        end else begin
          state_nxt = rscbw_pkg::ST_HMUL;
        end
      end
      rscbw_pkg::ST_HMUL: begin
        mul_a = {4'd0, x2_r};
        mul_b = {1'b0, p_r};
        state_nxt = rscbw_pkg::ST_HDIV;
      end
      rscbw_pkg::ST_HDIV: begin
        mul_a     = {4'd0, prod_r[59:30]};
        mul_b     = rscbw_pkg::horner_recip(sin_r, step_r + 2'd1);
        step_nxt  = step_r + 2'd1;
        state_nxt = rscbw_pkg::ST_DIV;
      end
      rscbw_pkg::ST_SINM: begin
        mul_a = {4'd0, x_r};
        mul_b = {1'b0, p_r};
        state_nxt = rscbw_pkg::ST_SINR;
      end
      rscbw_pkg::ST_SINR: begin
        p_nxt = prod_r[60:30];
        state_nxt = rscbw_pkg::ST_B;
      end
      rscbw_pkg::ST_B: begin
        mul_a = {19'd0, r0};
        mul_b = {1'b0, p_r};
        state_nxt = rscbw_pkg::ST_BR;
      end
      rscbw_pkg::ST_BR: begin
        b_nxt = b_round[45:14];
        mul_a = {2'd0, b_round[45:14]};
        mul_b = b_round[45:14];
        state_nxt = rscbw_pkg::ST_BB;
      end
      rscbw_pkg::ST_BB: begin
        q_nxt = prod_r[63:0];
        mul_a = {19'd0, r0};
        mul_b = {17'd0, r0};
        state_nxt = rscbw_pkg::ST_R0;
      end
      rscbw_pkg::ST_R0: begin
        r02_nxt = prod_r[29:0];
        mul_a = {22'd0, radius_r};
        mul_b = {20'd0, radius_r};
        state_nxt = rscbw_pkg::ST_RR;
      end
      rscbw_pkg::ST_RR: begin
        q_nxt = q_r + {8'd0, prod_r[23:0], 32'd0};
        state_nxt = rscbw_pkg::ST_CMP;
      end
      rscbw_pkg::ST_CMP: begin
        if (qdiff[64]) begin
          state_nxt = rscbw_pkg::ST_NEXT;
        end else begin
          q_nxt = qdiff[63:0];
          state_nxt = rscbw_pkg::ST_SQS;
        end
      end
      rscbw_pkg::ST_SQS: begin
        sq_start  = 1'b1;
        state_nxt = rscbw_pkg::ST_SQ;
      end
      rscbw_pkg::ST_SQ: begin
        if (sq_done) begin
          s_nxt = sq_root;
          state_nxt = rscbw_pkg::ST_FAR;
        end
      end
      rscbw_pkg::ST_FAR: begin
        if (far_s[34] || far_s == '0) begin
          state_nxt = rscbw_pkg::ST_NEXT;
        end else begin
          hit_nxt  = 1'b1;
          far_nxt  = far_s[32:0];
          near_nxt = near_s;
          state_nxt = rscbw_pkg::ST_FM;
        end
      end
      rscbw_pkg::ST_FM: begin
        mul_a = {1'b0, far_r};
        mul_b = {22'd0, rscbw_pkg::M_PER_KM};
        state_nxt = rscbw_pkg::ST_FD;
      end
      rscbw_pkg::ST_FD: begin
        div_start = 1'b1;
        div_dvd   = prod_r[53:22];
        div_dvs   = bsz_r;
        state_nxt = rscbw_pkg::ST_FDW;
      end
      rscbw_pkg::ST_FDW: begin
        if (div_done) begin
          if (r2b > maxb_r) maxb_nxt = r2b;
          if (!near_r[34] && near_r != '0) begin
            state_nxt = rscbw_pkg::ST_NM;
          end else begin
            // radar inside the circle
            if ({1'b0, fg_r} < minb_r) minb_nxt = {1'b0, fg_r};
            state_nxt = rscbw_pkg::ST_NEXT;
          end
        end
      end
      rscbw_pkg::ST_NM: begin
        mul_a = near_r[33:0];
        mul_b = {22'd0, rscbw_pkg::M_PER_KM};
        state_nxt = rscbw_pkg::ST_ND;
      end
      rscbw_pkg::ST_ND: begin
        div_start = 1'b1;
        div_dvd   = prod_r[53:22];
        div_dvs   = bsz_r;
        state_nxt = rscbw_pkg::ST_NDW;
      end
      rscbw_pkg::ST_NDW: begin
        if (div_done) begin
          if (r1b < {20'd0, minb_r}) minb_nxt = r1b[rscbw_pkg::MINB_W-1:0];
          state_nxt = rscbw_pkg::ST_NEXT;
        end
      end
      rscbw_pkg::ST_NEXT: begin
        if ({1'b0, idx_r} + 3'd1 == {1'b0, storm_count_r}) begin
          state_nxt = rscbw_pkg::ST_DONE;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = rscbw_pkg::ST_ANG0;
        end
      end
      rscbw_pkg::ST_DONE: begin
        ov_nxt = 1'b1;
        of_nxt = hit_r ? minb_r[rscbw_pkg::BIN_W-1:0] : rscbw_pkg::NONE_FIRST;
        ol_nxt = hit_r ? maxb_r : '0;
        on_nxt = !hit_r;
        state_nxt = rscbw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rscbw_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rscbw_pkg::ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    az1_r  <= az1_nxt;
    bsz_r  <= bsz_nxt;
    fg_r   <= fg_nxt;
    lg_r   <= lg_nxt;
    idx_r  <= idx_nxt;
    d_r    <= d_nxt;
    t_r    <= t_nxt;
    neg_r  <= neg_nxt;
    sin_r  <= sin_nxt;
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    p_r    <= p_nxt;
    step_r <= step_nxt;
    b_r    <= b_nxt;
    r02_r  <= r02_nxt;
    q_r    <= q_nxt;
    s_r    <= s_nxt;
    far_r  <= far_nxt;
    near_r <= near_nxt;
    hit_r  <= hit_nxt;
    minb_r <= minb_nxt;
    maxb_r <= maxb_nxt;
    of_r   <= of_nxt;
    ol_r   <= ol_nxt;
    on_r   <= on_nxt;
  end

  assign busy             = state_r != rscbw_pkg::ST_IDLE;
  assign out_valid        = ov_r;
  assign out_window_first = of_r;
  assign out_window_last  = ol_r;
  assign out_no_storm_hit = on_r;

  // result word only appears once the sequencer is back in idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  // a miss always reports an empty last bin
  a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_storm_hit) |-> (out_window_last == '0))
    else $error("miss with nonzero last bin");

  // an accepted word leaves idle next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");

endmodule

// ===== dv/radial_storm_circle_bin_window_checker.sv =====
module radial_storm_circle_bin_window_checker
  import rscbw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [AZ_W-1:0]    in_radial_azimuth,
  input  logic [BIN_W-1:0]   in_bin_size_m,
  input  logic [BIN_W-1:0]   in_radial_first_bin,
  input  logic [BIN_W-1:0]   in_radial_last_bin,
  input  logic               out_valid,
  input  logic [BIN_W-1:0]   out_window_first,
  input  logic [BIN_W-1:0]   out_window_last,
  input  logic               out_no_storm_hit,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output int                 fail_count,
  output int                 windows_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [BIN_W-1:0] first;
    logic [BIN_W-1:0] last;
    logic             none;
  } window_t;

  localparam u64_t Q30 = 64'd1 << 30;

  // shadow copy of the configuration
  logic [1:0]         shadow_count;
  logic [RANGE_W-1:0] shadow_range [3];
  logic [AZ_W-1:0]    shadow_az [3];
  logic [RAD_W-1:0]   shadow_radius;

  window_t windows_due [$];

  function automatic u64_t cos_poly(input u64_t t);
    u64_t x, x2, p;
    x  = t * 64'd1171271;
    x2 = (x * x) >> 30;
    p  = Q30 - x2 / 56;
    p  = Q30 - ((x2 * p) >> 30) / 30;
    p  = Q30 - ((x2 * p) >> 30) / 12;
    return Q30 - ((x2 * p) >> 30) / 2;
  endfunction

  function automatic u64_t sin_poly(input u64_t t);
    u64_t x, x2, p;
    x  = t * 64'd1171271;
    x2 = (x * x) >> 30;
    p  = Q30 - x2 / 72;
    p  = Q30 - ((x2 * p) >> 30) / 42;
    p  = Q30 - ((x2 * p) >> 30) / 20;
    p  = Q30 - ((x2 * p) >> 30) / 6;
    return (x * p) >> 30;
  endfunction

  function automatic u64_t root_floor(input u64_t v);
    u64_t res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // bin window of one radial over all valid storm circles
  function automatic window_t predict_window(input logic [AZ_W-1:0] az_in,
                                             input logic [BIN_W-1:0] bsz_in,
                                             input logic [BIN_W-1:0] fg,
                                             input logic [BIN_W-1:0] lg);
    window_t w;
    u64_t az1, az0, d, e, a, cm, r0, b, r02, sum, den, bsz, r1b, r2b, minb, maxb;
    longint s, sb, nearv, farv;
    logic neg, hit;
    int n;
    az1  = u64_t'(az_in) % 5760;
    bsz  = (bsz_in == 0) ? 1 : u64_t'(bsz_in);
    den  = bsz << 22;
    minb = MAX_BIN + 1;
    maxb = 0;
    hit  = 1'b0;
    n    = shadow_count;
    if (n > MAX_TRACKED) n = MAX_TRACKED;
    for (int i = 0; i < n; i++) begin
      r0  = shadow_range[i];
      az0 = u64_t'(shadow_az[i]) % 5760;
      d   = (az1 + 5760 - az0) % 5760;
      e   = (d > 2880) ? 5760 - d : d;
      neg = e > 1440;
      a   = neg ? 2880 - e : e;
      cm  = (a <= 720) ? cos_poly(a) : sin_poly(1440 - a);
      b   = (r0 * cm + 8192) >> 14;
      r02 = (r0 * r0) << 32;
      sum = ((u64_t'(shadow_radius) * shadow_radius) << 32) + b * b;
      if (sum < r02) continue;
      s     = longint'(root_floor(sum - r02));
      sb    = neg ? -longint'(b) : longint'(b);
      nearv = sb - s;
      farv  = sb + s;
      if (farv <= 0) continue;
      hit = 1'b1;
      r2b = (u64_t'(farv) * 1000) / den + 1;
      if (r2b > lg) r2b = lg;
      if (nearv > 0) begin
        r1b = (u64_t'(nearv) * 1000) / den + 1;
        if (r1b < fg) r1b = fg;
      end else begin
        r1b = fg;
      end
      if (r1b < minb) minb = r1b;
      if (r2b > maxb) maxb = r2b;
    end
    if (!hit) begin
      w.first = NONE_FIRST;
      w.last  = '0;
      w.none  = 1'b1;
    end else begin
      w.first = minb[BIN_W-1:0];
      w.last  = maxb[BIN_W-1:0];
      w.none  = 1'b0;
    end
    return w;
  endfunction

  assign windows_pending = windows_due.size();

  // follow register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count  <= '0;
      shadow_range  <= '{default: '0};
      shadow_az     <= '{default: '0};
      shadow_radius <= RAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STORM_COUNT: shadow_count    <= cfg_data[1:0];
        CFG_S0_RANGE:    shadow_range[0] <= cfg_data[RANGE_W-1:0];
        CFG_S0_AZ:       shadow_az[0]    <= cfg_data[AZ_W-1:0];
        CFG_S1_RANGE:    shadow_range[1] <= cfg_data[RANGE_W-1:0];
        CFG_S1_AZ:       shadow_az[1]    <= cfg_data[AZ_W-1:0];
        CFG_S2_RANGE:    shadow_range[2] <= cfg_data[RANGE_W-1:0];
        CFG_S2_AZ:       shadow_az[2]    <= cfg_data[AZ_W-1:0];
        CFG_RADIUS:      shadow_radius   <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // predict on each accepted radial word, compare each window word
  initial fail_count = 0;
  always @(posedge clk) begin
    window_t got, want;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_window_first, out_window_last, out_no_storm_hit};
        if (windows_due.size() == 0) begin
          $display("%0t: window word with none due: first %0d last %0d none %0b",
                   $time, got.first, got.last, got.none);
          fail_count++;
        end else begin
          want = windows_due.pop_front();
          if (got.first !== want.first) begin
            $display("%0t: window_first expected %0d actual %0d",
                     $time, want.first, got.first);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t: window_last expected %0d actual %0d",
                     $time, want.last, got.last);
            fail_count++;
          end
          if (got.none !== want.none) begin
            $display("%0t: no_storm_hit expected %0b actual %0b",
                     $time, want.none, got.none);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        windows_due.push_back(predict_window(in_radial_azimuth, in_bin_size_m,
                                             in_radial_first_bin, in_radial_last_bin));
    end
  end

endmodule

// ===== dv/radial_storm_circle_bin_window_test.sv =====
module radial_storm_circle_bin_window_test;
  import rscbw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [AZ_W-1:0]    in_radial_azimuth = '0;
  logic [BIN_W-1:0]   in_bin_size_m = '0;
  logic [BIN_W-1:0]   in_radial_first_bin = '0;
  logic [BIN_W-1:0]   in_radial_last_bin = '0;
  logic               out_valid;
  logic [BIN_W-1:0]   out_window_first;
  logic [BIN_W-1:0]   out_window_last;
  logic               out_no_storm_hit;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  int                 fail_count;
  int                 windows_pending;
  logic [AZ_W-1:0]    storm_az_now [3];

  always #6 clk = ~clk;

  radial_storm_circle_bin_window dut (.*);

  radial_storm_circle_bin_window_checker chk (.*);

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // present one radial word, hold until taken, then optional gap
  task automatic send_radial(input int unsigned az, input int unsigned bsz,
                             input int unsigned fg, input int unsigned lg,
                             input int gap);
    start               <= 1'b1;
    in_radial_azimuth   <= az[AZ_W-1:0];
    in_bin_size_m       <= bsz[BIN_W-1:0];
    in_radial_first_bin <= fg[BIN_W-1:0];
    in_radial_last_bin  <= lg[BIN_W-1:0];
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (windows_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic set_storms(input int cnt, input int unsigned r0, input int unsigned a0,
                            input int unsigned r1, input int unsigned a1,
                            input int unsigned r2, input int unsigned a2,
                            input int unsigned rad);
    write_reg(CFG_STORM_COUNT, cnt);
    write_reg(CFG_S0_RANGE, r0);
    write_reg(CFG_S0_AZ, a0);
    write_reg(CFG_S1_RANGE, r1);
    write_reg(CFG_S1_AZ, a1);
    write_reg(CFG_S2_RANGE, r2);
    write_reg(CFG_S2_AZ, a2);
    write_reg(CFG_RADIUS, rad);
    storm_az_now[0] = a0[AZ_W-1:0];
    storm_az_now[1] = a1[AZ_W-1:0];
    storm_az_now[2] = a2[AZ_W-1:0];
  endtask

  // random radial, mostly aimed close to a storm
  task automatic random_radial(input int gap);
    int unsigned az, bsz, fg, lg, k;
    k = $urandom_range(0, 2);
    if ($urandom_range(0, 9) < 7)
      az = (storm_az_now[k] % 5760 + 5760 + $urandom_range(0, 800) - 400) % 5760;
    else if ($urandom_range(0, 9) == 0)
      az = $urandom_range(5760, 8191);
    else
      az = $urandom_range(0, 5759);
    case ($urandom_range(0, 5))
      0: bsz = 250;
      1: bsz = 1000;
      2: bsz = $urandom_range(0, 4095);
      default: bsz = $urandom_range(50, 2000);
    endcase
    if ($urandom_range(0, 4) == 0) begin
      fg = $urandom_range(0, 4095);
      lg = $urandom_range(0, 4095);
    end else begin
      fg = $urandom_range(1, 20);
      lg = $urandom_range(fg, 2048);
    end
    send_radial(az, bsz, fg, lg, gap);
  endtask

  initial begin
    int unsigned rr [3];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    storm_az_now = '{default: '0};

    // reset configuration: no storms
    send_radial(0, 1000, 1, 2048, 0);
    send_radial(8191, 4095, 4095, 0, 1);
    drain();

    // directed: radar inside circle, behind radar, extremes, wrap, zero bin size
    set_storms(3, 0, 0, 32767, 5759, 1000, 2880, 4095);
    send_radial(0, 1, 1, 2048, 0);
    send_radial(5759, 1000, 1, 2048, 0);
    send_radial(2880, 250, 1, 2048, 0);
    send_radial(1440, 0, 5, 100, 2);
    send_radial(4320, 4095, 2048, 1, 0);
    send_radial(8191, 1000, 1, 4095, 0);
    send_radial(720, 4095, 4095, 4095, 1);
    drain();
    set_storms(3, 32767, 100, 2000, 7000, 640, 8191, 0);
    send_radial(100, 1000, 1, 2048, 0);
    send_radial(1060, 250, 1, 2048, 0);
    send_radial(2911, 1, 1, 2048, 0);
    send_radial(3000, 1000, 1, 2048, 1);
    drain();
    set_storms(2, 12800, 1000, 3000, 1200, 32767, 4000, 1280);
    send_radial(1000, 250, 1, 30, 0);
    send_radial(1100, 1000, 1, 2048, 0);
    send_radial(1200, 1, 3, 2048, 0);
    send_radial(2440, 500, 1, 2048, 0);
    send_radial(4000, 250, 1, 2048, 1);
    drain();
    set_storms(1, 200, 5000, 0, 0, 0, 0, 400);
    send_radial(5000, 250, 1, 2048, 0);
    send_radial(2120, 250, 1, 2048, 0);
    send_radial(5000, 4095, 7, 2, 1);
    drain();
    write_reg(CFG_RADIUS, 4095);

    // random phases with fresh settings
    for (int ph = 0; ph < 8; ph++) begin
      for (int k = 0; k < 3; k++)
        rr[k] = (ph == 0) ? 32767 : ($urandom_range(0, 3) == 0 ?
                $urandom_range(0, 32767) : $urandom_range(0, 16000));
      set_storms((ph == 1) ? 0 : $urandom_range(1, 3),
                 rr[0], $urandom_range(0, 8191), rr[1], $urandom_range(0, 8191),
                 rr[2], $urandom_range(0, 8191),
                 (ph == 0) ? 4095 : (ph == 2) ? 0 : $urandom_range(0, 4095));
      for (int i = 0; i < 180; i++) begin
        if (i == 90) begin
          start <= 1'b0;
          @(posedge clk);
          drain();
        end
        if (i >= 120 && i < 150)
          random_radial((i == 179) ? 1 : 0);
        else
          random_radial((i == 179 || i == 89) ? 1 : pick_gap());
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #300000000;
    $display("status: fail");
    $finish;
  end

endmodule
